### rtl/pspht_pkg.sv
// Package: widths, codes and state encoding for the point sprite pick hit test.
`timescale 1ns / 1ps
package pspht_pkg;
   localparam int unsigned DefMaxPoints = 65536;
   localparam int unsigned NumRegs      = 8;
   localparam int unsigned RegWidth     = 64;
   localparam int unsigned RegIdxWidth  = 3;
   localparam int unsigned ReqDataWidth = 128;
   localparam int unsigned RspDataWidth = 16;
   localparam int unsigned IndexWidth   = 16;
   localparam int unsigned DivWidth     = 64;

   typedef enum logic [2:0] {
      REG_MX_LO = 3'd0, REG_MX_HI = 3'd1, REG_MY_LO = 3'd2, REG_MY_HI = 3'd3,
      REG_MW_LO = 3'd4, REG_MW_HI = 3'd5, REG_PANEL = 3'd6, REG_REQPOS = 3'd7
   } reg_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL, ST_SUM, ST_DIVX, ST_DIVY, ST_PX, ST_PY, ST_TEST, ST_OUT
   } state_type;

   // 32x32 signed product
   typedef logic signed [63:0] prod_type;

   typedef struct packed {
      logic start;
      logic signed [DivWidth-1:0] num;
      logic signed [DivWidth-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic signed [DivWidth-1:0] quo;
   } div_rsp_type;

   function automatic logic signed [33:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) return 34'sd2147483647;
      if (v < -66'sd2147483648) return -34'sd2147483648;
      return v[33:0];
   endfunction
endpackage

### rtl/pspht_div.sv
// Iterative signed divider, truncating toward zero, one quotient bit per cycle.
`timescale 1ns / 1ps
module pspht_div (
   input  logic                   clock,
   input  logic                   reset,
   input  pspht_pkg::div_req_type div_req,
   output pspht_pkg::div_rsp_type div_rsp
);
   import pspht_pkg::*;
   localparam int unsigned CntWidth = $clog2(DivWidth + 1);

   logic                 busy_ff, busy_in;
   logic [CntWidth-1:0]  cnt_ff, cnt_in;
   logic [DivWidth-1:0]  rem_ff, rem_in, quo_ff, quo_in, den_ff, den_in;
   logic                 neg_ff, neg_in, done_ff, done_in;
   logic [DivWidth:0]    trial;
   logic [DivWidth-1:0]  shifted;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      shifted = {rem_ff[DivWidth-2:0], quo_ff[DivWidth-1]};
      trial   = {1'b0, shifted} - {1'b0, den_ff};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CntWidth'(DivWidth);
         rem_in  = '0;
         quo_in  = div_req.num[DivWidth-1] ? -div_req.num : div_req.num;
         den_in  = div_req.den[DivWidth-1] ? -div_req.den : div_req.den;
         neg_in  = div_req.num[DivWidth-1] ^ div_req.den[DivWidth-1];
      end else if (busy_ff) begin
         // shift one bit of the dividend in, subtract where it fits
         if (!trial[DivWidth]) begin
            rem_in = trial[DivWidth-1:0];
            quo_in = {quo_ff[DivWidth-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[DivWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = neg_ff ? -quo_ff : quo_ff;
endmodule

### rtl/point_sprite_pick_hit_test.sv
// Top level: projects points with one shared multiplier and divider, keeps the best hit.
// Each point runs nine multiply-add steps, two bit-serial divides by w, then scaling,
// the hit test and the finish state. Zero w skips the divides, scaling and test;
// an empty panel skips all arithmetic. One point at a time: req_tready is high
// only while idle, and a result still held in the output register stalls the last
// point of the next set. Sync reset clears the CSRs, state, best hit and output valid.
`timescale 1ns / 1ps
module point_sprite_pick_hit_test #(
   parameter int unsigned MAX_POINTS = pspht_pkg::DefMaxPoints
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // pos_x, pos_y, pos_z, sprite_size, point_index (low to high)
   input  logic [pspht_pkg::ReqDataWidth+15:0]  req_tdata,
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // item_id
   output logic [pspht_pkg::RspDataWidth-1:0]   rsp_tdata,
   // hit
   output logic                                 rsp_tuser,
   input  logic                                 csr_we,
   input  logic [pspht_pkg::RegIdxWidth-1:0]    csr_index,
   input  logic [pspht_pkg::RegWidth-1:0]       csr_wdata
);
   import pspht_pkg::*;

   logic [RegWidth-1:0] regs_ff [NumRegs];

   state_type st_ff, st_in;
   logic [3:0] step_ff, step_in;
   logic signed [31:0] px_ff, py_ff, pz_ff;
   logic [31:0]        size_ff;
   logic [IndexWidth-1:0] idx_ff;
   logic               last_ff;
   logic signed [65:0] acc_ff, acc_in;
   prod_type           prod_ff, prod_in;
   logic signed [33:0] cx_ff, cy_ff, cw_ff, cr_in;
   logic signed [33:0] nx_ff, ny_ff, n_in;
   logic signed [65:0] pxo_ff, pyo_ff;
   logic               found_ff, found_in;
   logic [IndexWidth-1:0] best_ff, best_in;
   logic               ovalid_ff, ovalid_in, ohit_ff, ohit_in;
   logic [IndexWidth-1:0] oid_ff, oid_in;
   logic signed [32:0] ma, mb;
   logic signed [65:0] mp;
   logic               mshift17;
   div_req_type        dreq;
   div_rsp_type        drsp;
   logic [1:0]         row;
   logic [1:0]         col;
   logic signed [31:0] coef, opnd;
   logic signed [65:0] dx, dy;
   logic [65:0]        adx, ady;
   logic               hit_now, idx_ok;

   pspht_div u_div (.clock(clock), .reset(reset), .div_req(dreq), .div_rsp(drsp));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumRegs; i++) regs_ff[i] <= '0;
      end else if (csr_we) begin
         regs_ff[csr_index] <= csr_wdata;
      end
   end

   // step = row*3 + col; row x,y,w; col x,y,z
   always_comb begin
      row  = (step_ff >= 4'd6) ? 2'd2 : (step_ff >= 4'd3) ? 2'd1 : 2'd0;
      col  = 2'(step_ff - {row, 1'b0} - {2'b0, row});
      unique case (col)
         2'd0:    begin coef = regs_ff[{row, 1'b0}][31:0];  opnd = px_ff; end
         2'd1:    begin coef = regs_ff[{row, 1'b0}][63:32]; opnd = py_ff; end
         default: begin coef = regs_ff[{row, 1'b1}][31:0];  opnd = pz_ff; end
      endcase
   end

   // shared multiplier: 32x32 magnitude product, shift, sign restore
   always_comb begin
      logic [31:0] ua;
      logic [31:0] ub;
      logic [63:0] um;
      logic [63:0] sh;
      logic neg;
      neg = ma[32] ^ mb[32];
      ua  = ma[32] ? 32'(-ma) : ma[31:0];
      ub  = mb[32] ? 32'(-mb) : mb[31:0];
      um  = {32'b0, ua} * {32'b0, ub};
      sh  = mshift17 ? (um >> 17) : (um >> 16);
      mp  = neg ? -$signed({2'b00, sh}) : $signed({2'b00, sh});
   end

   always_comb begin
      ma = {coef[31], coef};
      mb = {opnd[31], opnd};
      mshift17 = 1'b0;
      if (st_ff == ST_PX) begin
         ma = 33'(nx_ff + 34'sd65536);
         mb = {1'b0, regs_ff[REG_PANEL][31:0]};
         mshift17 = 1'b1;
      end else if (st_ff == ST_PY) begin
         ma = 33'(34'sd65536 - ny_ff);
         mb = {1'b0, regs_ff[REG_PANEL][63:32]};
         mshift17 = 1'b1;
      end
   end

   assign dx = pxo_ff - 66'($signed(regs_ff[REG_REQPOS][31:0]));
   assign dy = pyo_ff - 66'($signed(regs_ff[REG_REQPOS][63:32]));
   assign adx = dx[65] ? 66'(-dx) : 66'(dx);
   assign ady = dy[65] ? 66'(-dy) : 66'(dy);
   assign idx_ok = (32'(idx_ff) < 32'(MAX_POINTS - 1)) || (32'(idx_ff) == 32'(MAX_POINTS - 1));
   assign hit_now = idx_ok && (adx <= 66'(size_ff >> 1)) && (ady <= 66'(size_ff >> 1));
   // full row total on the last column of a row
   assign cr_in = sat32(acc_ff + 66'(prod_ff) + 66'($signed(regs_ff[{row, 1'b1}][63:32])));
   assign n_in  = sat32(66'(drsp.quo));

   always_comb begin
      st_in = st_ff;
      step_in = step_ff;
      acc_in = acc_ff;
      prod_in = prod_ff;
      found_in = found_ff;
      best_in = best_ff;
      ovalid_in = ovalid_ff;
      ohit_in = ohit_ff;
      oid_in = oid_ff;
      dreq.start = 1'b0;
      dreq.num = 64'(cx_ff) <<< 16;
      dreq.den = 64'(cw_ff);
      if (ovalid_ff && rsp_tready) ovalid_in = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               st_in = (regs_ff[REG_PANEL][31:0] == '0 || regs_ff[REG_PANEL][63:32] == '0)
                     ? ST_TEST : ST_MUL;
               step_in = '0;
               acc_in = '0;
            end
         end
         ST_MUL: begin
            prod_in = 64'(mp);
            st_in = ST_SUM;
         end
         ST_SUM: begin
            acc_in = acc_ff + 66'(prod_ff);
            if (col == 2'd2) acc_in = '0;
            step_in = step_ff + 1'b1;
            st_in = ST_MUL;
            if (step_ff == 4'd8) begin
               if (cr_in == '0) st_in = ST_OUT;
               else begin
                  st_in = ST_DIVX;
                  dreq.start = 1'b1;
                  // w lands in cw_ff only at this edge
                  dreq.den = 64'(cr_in);
               end
            end
         end
         ST_DIVX: begin
            if (drsp.done) begin
               dreq.start = 1'b1;
               dreq.num = 64'(cy_ff) <<< 16;
               st_in = ST_DIVY;
            end
         end
         ST_DIVY: if (drsp.done) st_in = ST_PX;
         ST_PX: st_in = ST_PY;
         ST_PY: st_in = ST_TEST;
         ST_TEST: begin
            // empty panel comes here directly and px/py are not used
            if (hit_now && regs_ff[REG_PANEL][31:0] != '0 && regs_ff[REG_PANEL][63:32] != '0
                && (!found_ff || idx_ff > best_ff)) begin
               found_in = 1'b1;
               best_in = idx_ff;
            end
            st_in = ST_OUT;
         end
         ST_OUT: begin
            if (!last_ff) st_in = ST_IDLE;
            else if (!ovalid_ff || rsp_tready) begin
               ovalid_in = 1'b1;
               ohit_in = found_ff;
               oid_in = found_ff ? best_ff : '0;
               found_in = 1'b0;
               best_in = '0;
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         step_ff <= '0;
         found_ff <= 1'b0;
         best_ff <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         step_ff <= step_in;
         found_ff <= found_in;
         best_ff <= best_in;
         ovalid_ff <= ovalid_in;
      end
      acc_ff <= acc_in;
      prod_ff <= prod_in;
      ohit_ff <= ohit_in;
      oid_ff <= oid_in;
      if (st_ff == ST_IDLE && req_tvalid) begin
         px_ff <= req_tdata[31:0];
         py_ff <= req_tdata[63:32];
         pz_ff <= req_tdata[95:64];
         size_ff <= req_tdata[127:96];
         idx_ff <= req_tdata[143:128];
         last_ff <= req_tlast;
      end
      if (st_ff == ST_SUM && col == 2'd2) begin
         unique case (row)
            2'd0:    cx_ff <= sat32(acc_ff + 66'(prod_ff)
                              + 66'($signed(regs_ff[REG_MX_HI][63:32])));
            2'd1:    cy_ff <= sat32(acc_ff + 66'(prod_ff)
                              + 66'($signed(regs_ff[REG_MY_HI][63:32])));
            default: cw_ff <= sat32(acc_ff + 66'(prod_ff)
                              + 66'($signed(regs_ff[REG_MW_HI][63:32])));
         endcase
      end
      if (st_ff == ST_DIVX && drsp.done) nx_ff <= n_in;
      if (st_ff == ST_DIVY && drsp.done) ny_ff <= n_in;
      if (st_ff == ST_PX) pxo_ff <= mp;
      if (st_ff == ST_PY) pyo_ff <= mp;
   end

   assign req_tready = (st_ff == ST_IDLE);
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = oid_ff;
   assign rsp_tuser  = ohit_ff;
endmodule

### rtl/pspht_checker.sv
// Port-level checker for the pick hit test, bound to the top level.
`timescale 1ns / 1ps
module pspht_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tuser
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped while stalled");
   a_nohit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 16'd0)
      else $error("miss with nonzero id");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready right after transfer");
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");
endmodule

bind point_sprite_pick_hit_test pspht_checker u_chk (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
);

### bench/tb_point_sprite_pick_hit_test.sv
// Testbench for the point sprite pick hit test: directed table, then random point sets.
`timescale 1ns / 1ps
module tb_point_sprite_pick_hit_test;
   import pspht_pkg::*;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic [31:0]        size;
      logic [15:0]        idx;
      logic               last;
   } point_type;

   typedef struct {
      point_type pt;
      bit        typed;
      bit        ehit;
      logic [15:0] eid;
   } row_type;

   typedef struct {
      bit          hit;
      logic [15:0] id;
   } pick_type;

   localparam logic signed [127:0] QOne = 128'sd65536;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [ReqDataWidth+15:0] req_tdata;
   logic req_tlast;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RspDataWidth-1:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_we;
   logic [RegIdxWidth-1:0] csr_index;
   logic [RegWidth-1:0] csr_wdata;

   logic [63:0] csr_copy[NumRegs];
   bit          pick_found;
   logic [15:0] pick_best;
   pick_type    expected_q[$];
   row_type     rows[$];
   int          mismatches = 0;
   bit          quiet;
   int          scene_w;
   int          scene_h;

   point_sprite_pick_hit_test u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic signed [127:0] clamp_q(input logic signed [127:0] v);
      if (v > 128'sd2147483647) return 128'sd2147483647;
      if (v < -128'sd2147483648) return -128'sd2147483648;
      return v;
   endfunction

   // product shifted right, rounded toward zero
   function automatic logic signed [127:0] scaled_product(input logic signed [127:0] a,
         input logic signed [127:0] b, input int sh);
      logic signed [127:0] p;
      p = a * b;
      if (p < 0) return -((-p) >>> sh);
      return p >>> sh;
   endfunction

   function automatic logic signed [127:0] coef(input int r, input bit hi);
      logic signed [31:0] w;
      w = hi ? csr_copy[r][63:32] : csr_copy[r][31:0];
      return 128'(w);
   endfunction

   function automatic logic signed [127:0] clip_row(input int r, input point_type pt);
      logic signed [127:0] acc;
      acc = scaled_product(coef(2*r, 0), pt.x, 16) + scaled_product(coef(2*r, 1), pt.y, 16)
          + scaled_product(coef(2*r+1, 0), pt.z, 16) + coef(2*r+1, 1);
      return clamp_q(acc);
   endfunction

   function automatic bit sprite_covers(input point_type pt);
      logic signed [127:0] pw, ph, rx, ry, cx, cy, cw, nx, ny, px, py, dx, dy, half;
      pw = {96'd0, csr_copy[REG_PANEL][31:0]};
      ph = {96'd0, csr_copy[REG_PANEL][63:32]};
      rx = coef(REG_REQPOS, 0);
      ry = coef(REG_REQPOS, 1);
      half = {96'd0, pt.size >> 1};
      if (pw == 0 || ph == 0) return 0;
      cx = clip_row(0, pt);
      cy = clip_row(1, pt);
      cw = clip_row(2, pt);
      if (cw == 0) return 0;
      nx = clamp_q((cx * QOne) / cw);
      ny = clamp_q((cy * QOne) / cw);
      px = scaled_product(nx + QOne, pw, 17);
      py = scaled_product(QOne - ny, ph, 17);
      dx = px - rx;
      dy = py - ry;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      return dx <= half && dy <= half;
   endfunction

   // update the best hit; returns 1 with the pick when the set closes
   function automatic bit track_pick(input point_type pt, output pick_type pk);
      if (sprite_covers(pt) && (!pick_found || pt.idx > pick_best)) begin
         pick_found = 1;
         pick_best  = pt.idx;
      end
      pk.hit = pick_found;
      pk.id  = pick_found ? pick_best : 16'd0;
      if (!pt.last) return 0;
      pick_found = 0;
      pick_best  = 0;
      return 1;
   endfunction

   // the enable drops between writes
   task automatic write_csr(input reg_idx_type r, input logic [63:0] v);
      csr_we    <= 1'b1;
      csr_index <= r;
      csr_wdata <= v;
      csr_copy[r] = v;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain;
      while (expected_q.size() != 0) @(posedge clock);
      // a non-last point may still be in flight
      repeat (200) @(posedge clock);
   endtask

   task automatic send_point(input point_type pt, input bit typed, input bit ehit,
         input logic [15:0] eid);
      pick_type pk;
      req_tdata  <= {pt.idx, pt.size, pt.z, pt.y, pt.x};
      req_tlast  <= pt.last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (track_pick(pt, pk)) begin
         if (typed) begin
            pk.hit = ehit;
            pk.id  = eid;
         end
         expected_q.push_back(pk);
      end
      if (!quiet && $urandom_range(99) < 17) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 200)) @(posedge clock);
      end
   endtask

   function automatic point_type make_point(input logic signed [31:0] x,
         input logic signed [31:0] y, input logic signed [31:0] z, input logic [31:0] size,
         input logic [15:0] idx, input logic last);
      point_type pt;
      pt.x = x; pt.y = y; pt.z = z; pt.size = size; pt.idx = idx; pt.last = last;
      return pt;
   endfunction

   task automatic add_row(input point_type pt, input bit typed, input bit ehit,
         input logic [15:0] eid);
      row_type r;
      r.pt = pt; r.typed = typed; r.ehit = ehit; r.eid = eid;
      rows.push_back(r);
   endtask

   // x and y pass through, w comes from z, so z of zero gives zero w
   task automatic load_scene;
      scene_w = $urandom_range(1, 1024);
      scene_h = $urandom_range(1, 1024);
      write_csr(REG_MX_LO, {32'h0, 32'h10000});
      write_csr(REG_MX_HI, 64'h0);
      write_csr(REG_MY_LO, {32'h10000, 32'h0});
      write_csr(REG_MY_HI, 64'h0);
      write_csr(REG_MW_LO, 64'h0);
      write_csr(REG_MW_HI, {32'h0, 32'h10000});
      write_csr(REG_PANEL, {scene_h[15:0], 16'h0, scene_w[15:0], 16'h0});
      write_csr(REG_REQPOS, {$urandom_range(0, scene_h << 16), $urandom_range(0, scene_w << 16)});
   endtask

   function automatic logic [31:0] small_coef;
      return $urandom_range(0, 262144) - 131072;
   endfunction

   task automatic load_phase(input int ph);
      int r;
      case (ph % 6)
         0, 5: load_scene();
         1: begin
            load_scene();
            for (r = REG_MX_LO; r <= REG_MW_HI; r++)
               write_csr(reg_idx_type'(r), {small_coef(), small_coef()});
         end
         2: for (r = REG_MX_LO; r <= REG_REQPOS; r++)
               write_csr(reg_idx_type'(r), {$urandom, $urandom});
         3: begin
            for (r = REG_MX_LO; r <= REG_MW_HI; r++)
               write_csr(reg_idx_type'(r), (r % 2) ? 64'h8000_0000_7FFF_FFFF
                                                   : 64'h7FFF_FFFF_8000_0000);
            write_csr(REG_PANEL, 64'hFFFF_FFFF_FFFF_FFFF);
            write_csr(REG_REQPOS, 64'h7FFF_FFFF_8000_0000);
         end
         default: begin
            load_scene();
            write_csr(REG_PANEL, {$urandom, 32'h0});
         end
      endcase
   endtask

   function automatic point_type random_point(input bit last);
      point_type pt;
      logic signed [31:0] zz;
      if ($urandom_range(99) < 15) begin
         pt = make_point($urandom, $urandom, $urandom, $urandom, 16'($urandom), last);
      end else begin
         case ($urandom_range(19))
            0: zz = 0;
            1, 2: zz = $urandom_range(32768, 131072);
            default: zz = 32'sd65536;
         endcase
         pt = make_point($urandom_range(0, 131072) - 65536, $urandom_range(0, 131072) - 65536,
                         zz, $urandom_range(0, 600 << 16), 16'($urandom_range(0, 65535)),
                         last);
         if ($urandom_range(3) == 0) pt.idx = 16'($urandom_range(0, 7));
      end
      return pt;
   endfunction

   // check each result transfer against the oldest expectation
   always @(posedge clock) begin
      pick_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: hit %0b id %0d", rsp_tuser, rsp_tdata);
         end else begin
            want = expected_q.pop_front();
            if (rsp_tuser !== want.hit || rsp_tdata !== want.id) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: expected hit %0b id %0d, got hit %0b id %0d",
                           want.hit, want.id, rsp_tuser, rsp_tdata);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= quiet || ($urandom_range(99) >= 17);
   end

   initial begin
      #50ms;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      int i, ph, n, setlen, lim;
      point_type pt;
      clock = 0;
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      req_tlast = 0;
      csr_we = 0;
      csr_index = REG_MX_LO;
      csr_wdata = '0;
      quiet = 0;
      pick_found = 0;
      pick_best = 0;
      for (i = 0; i < NumRegs; i++) csr_copy[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // registers at reset: empty panel, nothing can hit
      add_row(make_point(0, 0, 0, 0, 0, 1), 1, 0, 0);
      add_row(make_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'hFFFF_FFFF,
                         16'hFFFF, 1), 1, 0, 0);
      foreach (rows[k]) send_point(rows[k].pt, rows[k].typed, rows[k].ehit, rows[k].eid);
      req_tvalid <= 1'b0;
      drain();
      rows.delete();

      load_scene();
      write_csr(REG_REQPOS, {scene_h[15:0], 15'h0, 1'b0, scene_w[15:0], 15'h0, 1'b0} >> 1);
      // point at the origin lands on the panel center, where the request sits
      add_row(make_point(0, 0, 32'sd65536, 0, 5, 1), 1, 1, 5);
      add_row(make_point(0, 0, 0, 32'hFFFF_FFFF, 6, 1), 1, 0, 0);
      add_row(make_point(32'sd65536, 0, 32'sd65536, 2 << 16, 7, 0), 0, 0, 0);
      add_row(make_point(0, 0, 32'sd65536, 2 << 16, 3, 1), 0, 0, 0);
      add_row(make_point(0, 0, 32'sd65536, 2 << 16, 9, 0), 0, 0, 0);
      add_row(make_point(0, 0, 32'sd65536, 2 << 16, 9, 1), 0, 0, 0);
      add_row(make_point(0, 0, 32'sd65536, 4 << 16, 20, 0), 0, 0, 0);
      add_row(make_point(0, 0, 32'sd65536, 4 << 16, 10, 0), 0, 0, 0);
      add_row(make_point(32'sh7FFF_FFFF, 0, 32'sd65536, 0, 0, 1), 0, 0, 0);
      add_row(make_point(0, 0, 32'sd65536, 32'hFFFF_FFFF, 16'hFFFF, 1), 1, 1, 16'hFFFF);
      add_row(make_point(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'hFFFF_FFFF,
                         16'hFFFF, 0), 0, 0, 0);
      add_row(make_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'h1, 0, 1),
              0, 0, 0);
      add_row(make_point(-32'sd65536, 32'sd65536, 32'sd65536, 32'h7FFF_FFFF, 1, 1), 0, 0, 0);
      foreach (rows[k]) send_point(rows[k].pt, rows[k].typed, rows[k].ehit, rows[k].eid);
      req_tvalid <= 1'b0;
      drain();

      for (ph = 0; ph < 6; ph++) begin
         load_phase(ph);
         quiet = (ph == 5);
         n = 0;
         while (n < 250) begin
            setlen = $urandom_range(1, 8);
            for (i = 0; i < setlen; i++) begin
               pt = random_point(i == setlen - 1);
               send_point(pt, 0, 0, 0);
               n++;
            end
         end
         req_tvalid <= 1'b0;
         req_tlast  <= 1'b0;
         drain();
      end
      quiet = 0;

      lim = 0;
      while (expected_q.size() != 0 && lim < 100000) begin
         @(posedge clock);
         lim++;
      end
      repeat (200) @(posedge clock);
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
